[design/cursor_list_engine_assert.svh]
// ---------------------------------------------------------------------------
// cursor list engine assertion macros
// concurrent checks sampled on the rising clock edge, off while in reset
// ---------------------------------------------------------------------------
`ifndef CURSOR_LIST_ENGINE_ASSERT_SVH
`define CURSOR_LIST_ENGINE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define CLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cursor list engine: check failed");

// consequent holds in the cycle after the antecedent
`define CLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cursor list engine: check failed");

`endif

[design/cle_pkg.sv]
// ---------------------------------------------------------------------------
// cle_pkg
// shared constants, operation and status codes for the cursor list engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cle_pkg;

  // default sizes
  localparam int unsigned PoolNodesDef = 64;
  localparam int unsigned DataWidthDef = 32;

  // fixed field widths
  localparam int unsigned FuncW   = 4;
  localparam int unsigned StatusW = 2;

  // operation codes
  typedef enum logic [FuncW-1:0] {
    FN_QUERY     = 4'd0,
    FN_CLEAR     = 4'd1,
    FN_SET       = 4'd2,
    FN_FRONT     = 4'd3,
    FN_BACK      = 4'd4,
    FN_PREV      = 4'd5,
    FN_NEXT      = 4'd6,
    FN_PREPEND   = 4'd7,
    FN_APPEND    = 4'd8,
    FN_INS_B     = 4'd9,
    FN_INS_A     = 4'd10,
    FN_DEL_FRONT = 4'd11,
    FN_DEL_BACK  = 4'd12,
    FN_DEL_CUR   = 4'd13,
    FN_FIND      = 4'd14
  } cle_func_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_NOCUR  = 2'd2,
    ST_FULL   = 2'd3
  } cle_status_e;

  // write enables of the three node memories
  typedef struct packed {
    logic data;
    logic next;
    logic prev;
  } cle_wen_t;

endpackage

[design/cursor_list_engine.sv]
// ---------------------------------------------------------------------------
// cursor_list_engine
// doubly linked list of data words in a node pool with a free list and a cursor
// ---------------------------------------------------------------------------
// usage
//   s_axis carries one operation per transaction: tdata = {item_data, func}.
//   m_axis returns exactly one result per operation, in order.
//   each operation runs alone: s_axis_tready_o is high only while the engine
//   waits for work. the node memories have a single read port, and the three
//   output words are fetched through it as well. a find walks the list one
//   node a cycle, and a clear rebuilds the free list one node a cycle.
//   after reset the same rebuild pass runs before the first operation is
//   taken; no result is produced for it.
//   the result sits in an output register: the next operation is taken while
//   it waits, and that operation holds in its last step until m_axis drains.
//   errors (empty list, no cursor, full pool) leave the state unchanged.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cursor_list_engine #(
  parameter int unsigned POOL_NODES = cle_pkg::PoolNodesDef,
  parameter int unsigned DATA_WIDTH = cle_pkg::DataWidthDef,
  localparam int unsigned AW    = $clog2(POOL_NODES),
  localparam int unsigned LW    = $clog2(POOL_NODES + 1),
  localparam int unsigned CNT_W = LW,
  localparam int unsigned IDX_W = $clog2(POOL_NODES) + 1,
  localparam int unsigned IN_W  = cle_pkg::FuncW + DATA_WIDTH,
  localparam int unsigned IN_TW = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = cle_pkg::StatusW + CNT_W + IDX_W + 3 * DATA_WIDTH + 1,
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // func, item_data
  input  logic [IN_TW-1:0]  s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // status, list_length, cursor_index, cursor_data, front_data, back_data, found
  output logic [OUT_TW-1:0] m_axis_tdata_o
);

  localparam logic [LW-1:0] NullLink = LW'(POOL_NODES);
  localparam logic [AW-1:0] LastNode = AW'(POOL_NODES - 1);

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_EXEC  = 15'b000000000000100,
    S_ALLOC = 15'b000000000001000,
    S_W1    = 15'b000000000010000,
    S_W2    = 15'b000000000100000,
    S_U1    = 15'b000000001000000,
    S_U2    = 15'b000000010000000,
    S_MOVE  = 15'b000000100000000,
    S_FIND  = 15'b000001000000000,
    S_OUT_F = 15'b000010000000000,
    S_OUT_B = 15'b000100000000000,
    S_OUT_C = 15'b001000000000000,
    S_DONE  = 15'b010000000000000,
    S_SPARE = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // list registers
  logic [LW-1:0]           free_q, free_d;
  logic [LW-1:0]           front_q, front_d;
  logic [LW-1:0]           back_q, back_d;
  logic [LW-1:0]           cur_q, cur_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [IDX_W-1:0] pos_q, pos_d;

  // operation registers
  logic [cle_pkg::FuncW-1:0]   func_q, func_d;
  logic [DATA_WIDTH-1:0]       word_q, word_d;
  logic [cle_pkg::StatusW-1:0] status_q, status_d;
  logic                        found_q, found_d;
  logic [LW-1:0]               pl_q, pl_d;
  logic [LW-1:0]               ql_q, ql_d;
  logic [AW-1:0]               node_q, node_d;
  logic [AW-1:0]               clr_q, clr_d;
  logic                        rep_q, rep_d;
  logic [DATA_WIDTH-1:0]       fw_q, fw_d;
  logic [DATA_WIDTH-1:0]       bw_q, bw_d;

  // output register
  logic              mvalid_q, mvalid_d;
  logic [OUT_W-1:0]  mdata_q, mdata_d;

  // memory port signals
  logic                  ren;
  logic [AW-1:0]         raddr;
  cle_pkg::cle_wen_t     wen;
  logic [AW-1:0]         d_waddr, n_waddr, p_waddr;
  logic [DATA_WIDTH-1:0] d_wdata;
  logic [LW-1:0]         n_wdata, p_wdata;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [LW-1:0]         rd_next, rd_prev;

  logic empty, nocur, full, s_fire, m_free;
  logic [DATA_WIDTH-1:0] cw;

  assign empty  = (cnt_q == '0);
  assign nocur  = (cur_q == NullLink);
  assign full   = (free_q == NullLink);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign m_free = !mvalid_q || m_axis_tready_i;
  assign cw     = nocur ? '0 : rd_data;

  cle_node_mem #(
    .POOL_NODES(POOL_NODES),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .ren_i     (ren),
    .raddr_i   (raddr),
    .wen_i     (wen),
    .d_waddr_i (d_waddr),
    .d_wdata_i (d_wdata),
    .n_waddr_i (n_waddr),
    .n_wdata_i (n_wdata),
    .p_waddr_i (p_waddr),
    .p_wdata_i (p_wdata),
    .rd_data_o (rd_data),
    .rd_next_o (rd_next),
    .rd_prev_o (rd_prev)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    free_d   = free_q;
    front_d  = front_q;
    back_d   = back_q;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    func_d   = func_q;
    word_d   = word_q;
    status_d = status_q;
    found_d  = found_q;
    pl_d     = pl_q;
    ql_d     = ql_q;
    node_d   = node_q;
    clr_d    = clr_q;
    rep_d    = rep_q;
    fw_d     = fw_q;
    bw_d     = bw_q;
    mvalid_d = mvalid_q;
    mdata_d  = mdata_q;
    ren      = 1'b0;
    raddr    = '0;
    wen      = '0;
    d_waddr  = '0;
    d_wdata  = '0;
    n_waddr  = '0;
    n_wdata  = '0;
    p_waddr  = '0;
    p_wdata  = '0;

    // result taken downstream
    if (mvalid_q && m_axis_tready_i) begin
      mvalid_d = 1'b0;
    end

    case (state_q)
      // rebuild the free list one node a cycle
      S_CLEAR: begin
        wen.next = 1'b1;
        wen.prev = 1'b1;
        n_waddr  = clr_q;
        n_wdata  = LW'(clr_q) + LW'(1);
        p_waddr  = clr_q;
        p_wdata  = NullLink;
        clr_d    = clr_q + AW'(1);
        if (clr_q == LastNode) begin
          clr_d   = '0;
          state_d = rep_q ? S_OUT_F : S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_fire) begin
          func_d   = s_axis_tdata_i[cle_pkg::FuncW-1:0];
          word_d   = s_axis_tdata_i[cle_pkg::FuncW +: DATA_WIDTH];
          status_d = cle_pkg::ST_OK;
          found_d  = 1'b0;
          state_d  = S_EXEC;
        end
      end

      // decode, check and issue the first read
      S_EXEC: begin
        state_d = S_OUT_F;
        case (func_q)
          cle_pkg::FN_CLEAR: begin
            free_d  = '0;
            front_d = NullLink;
            back_d  = NullLink;
            cur_d   = NullLink;
            cnt_d   = '0;
            pos_d   = '1;
            clr_d   = '0;
            rep_d   = 1'b1;
            state_d = S_CLEAR;
          end
          cle_pkg::FN_SET: begin
            if (!empty && !nocur) begin
              wen.data = 1'b1;
              d_waddr  = cur_q[AW-1:0];
              d_wdata  = word_q;
            end
          end
          cle_pkg::FN_FRONT: begin
            if (!empty) begin
              cur_d = front_q;
              pos_d = '0;
            end
          end
          cle_pkg::FN_BACK: begin
            if (!empty) begin
              cur_d = back_q;
              pos_d = IDX_W'(cnt_q - CNT_W'(1));
            end
          end
          cle_pkg::FN_PREV, cle_pkg::FN_NEXT: begin
            if (!nocur) begin
              if ((func_q == cle_pkg::FN_PREV && cur_q == front_q) ||
                  (func_q == cle_pkg::FN_NEXT && cur_q == back_q)) begin
                cur_d = NullLink;
                pos_d = '1;
              end else begin
                ren     = 1'b1;
                raddr   = cur_q[AW-1:0];
                state_d = S_MOVE;
              end
            end
          end
          cle_pkg::FN_PREPEND, cle_pkg::FN_APPEND: begin
            if (full) begin
              status_d = cle_pkg::ST_FULL;
            end else begin
              pl_d    = (func_q == cle_pkg::FN_PREPEND) ? NullLink : back_q;
              ql_d    = (func_q == cle_pkg::FN_PREPEND) ? front_q : NullLink;
              ren     = 1'b1;
              raddr   = free_q[AW-1:0];
              state_d = S_W1;
            end
          end
          cle_pkg::FN_INS_B, cle_pkg::FN_INS_A: begin
            if (empty) begin
              status_d = cle_pkg::ST_EMPTY;
            end else if (nocur) begin
              status_d = cle_pkg::ST_NOCUR;
            end else if (full) begin
              status_d = cle_pkg::ST_FULL;
            end else begin
              ren     = 1'b1;
              raddr   = cur_q[AW-1:0];
              state_d = S_ALLOC;
            end
          end
          cle_pkg::FN_DEL_FRONT, cle_pkg::FN_DEL_BACK: begin
            if (empty) begin
              status_d = cle_pkg::ST_EMPTY;
            end else begin
              node_d  = (func_q == cle_pkg::FN_DEL_FRONT) ? front_q[AW-1:0] : back_q[AW-1:0];
              ren     = 1'b1;
              raddr   = node_d;
              state_d = S_U1;
            end
          end
          cle_pkg::FN_DEL_CUR: begin
            if (empty) begin
              status_d = cle_pkg::ST_EMPTY;
            end else if (nocur) begin
              status_d = cle_pkg::ST_NOCUR;
            end else begin
              node_d  = cur_q[AW-1:0];
              ren     = 1'b1;
              raddr   = cur_q[AW-1:0];
              state_d = S_U1;
            end
          end
          cle_pkg::FN_FIND: begin
            if (front_q != NullLink) begin
              ren     = 1'b1;
              raddr   = front_q[AW-1:0];
              state_d = S_FIND;
            end
          end
          default: begin
            state_d = S_OUT_F;
          end
        endcase
      end

      // insert around the cursor: neighbours known, fetch free successor
      S_ALLOC: begin
        if (func_q == cle_pkg::FN_INS_B) begin
          pl_d = rd_prev;
          ql_d = cur_q;
        end else begin
          pl_d = cur_q;
          ql_d = rd_next;
        end
        ren     = 1'b1;
        raddr   = free_q[AW-1:0];
        state_d = S_W1;
      end

      // new node data and back link, predecessor forward link
      S_W1: begin
        wen.data = 1'b1;
        d_waddr  = free_q[AW-1:0];
        d_wdata  = word_q;
        wen.prev = 1'b1;
        p_waddr  = free_q[AW-1:0];
        p_wdata  = pl_q;
        if (pl_q != NullLink) begin
          wen.next = 1'b1;
          n_waddr  = pl_q[AW-1:0];
          n_wdata  = free_q;
        end
        state_d = S_W2;
      end

      // new node forward link, successor back link, registers
      S_W2: begin
        wen.next = 1'b1;
        n_waddr  = free_q[AW-1:0];
        n_wdata  = ql_q;
        if (ql_q != NullLink) begin
          wen.prev = 1'b1;
          p_waddr  = ql_q[AW-1:0];
          p_wdata  = free_q;
        end
        if (pl_q == NullLink) begin
          front_d = free_q;
        end
        if (ql_q == NullLink) begin
          back_d = free_q;
        end
        free_d = rd_next;
        cnt_d  = cnt_q + CNT_W'(1);
        if ((func_q == cle_pkg::FN_PREPEND && !nocur) || func_q == cle_pkg::FN_INS_B) begin
          pos_d = pos_q + IDX_W'(1);
        end
        state_d = S_OUT_F;
      end

      // bypass the removed node, fix the cursor
      S_U1: begin
        if (rd_prev != NullLink) begin
          wen.next = 1'b1;
          n_waddr  = rd_prev[AW-1:0];
          n_wdata  = rd_next;
        end else begin
          front_d = rd_next;
        end
        if (rd_next != NullLink) begin
          wen.prev = 1'b1;
          p_waddr  = rd_next[AW-1:0];
          p_wdata  = rd_prev;
        end else begin
          back_d = rd_prev;
        end
        if (func_q == cle_pkg::FN_DEL_CUR || cur_q == LW'(node_q)) begin
          cur_d = NullLink;
          pos_d = '1;
        end else if (func_q == cle_pkg::FN_DEL_FRONT && !nocur) begin
          pos_d = pos_q - IDX_W'(1);
        end
        state_d = S_U2;
      end

      // return the node to the free list
      S_U2: begin
        wen.next = 1'b1;
        n_waddr  = node_q;
        n_wdata  = free_q;
        wen.prev = 1'b1;
        p_waddr  = node_q;
        p_wdata  = NullLink;
        free_d   = LW'(node_q);
        cnt_d    = cnt_q - CNT_W'(1);
        state_d  = S_OUT_F;
      end

      // step the cursor over a link
      S_MOVE: begin
        if (func_q == cle_pkg::FN_PREV) begin
          cur_d = rd_prev;
          pos_d = pos_q - IDX_W'(1);
        end else begin
          cur_d = rd_next;
          pos_d = pos_q + IDX_W'(1);
        end
        state_d = S_OUT_F;
      end

      // walk the list one node a cycle
      S_FIND: begin
        if (rd_data == word_q) begin
          found_d = 1'b1;
          state_d = S_OUT_F;
        end else if (rd_next == NullLink) begin
          state_d = S_OUT_F;
        end else begin
          ren   = 1'b1;
          raddr = rd_next[AW-1:0];
        end
      end

      // fetch front, back and cursor words
      S_OUT_F: begin
        rep_d = 1'b0;
        if (front_q != NullLink) begin
          ren   = 1'b1;
          raddr = front_q[AW-1:0];
        end
        state_d = S_OUT_B;
      end

      S_OUT_B: begin
        fw_d = (front_q != NullLink) ? rd_data : '0;
        if (back_q != NullLink) begin
          ren   = 1'b1;
          raddr = back_q[AW-1:0];
        end
        state_d = S_OUT_C;
      end

      S_OUT_C: begin
        bw_d = (back_q != NullLink) ? rd_data : '0;
        if (!nocur) begin
          ren   = 1'b1;
          raddr = cur_q[AW-1:0];
        end
        state_d = S_DONE;
      end

      // load the output register once it is free
      S_DONE: begin
        if (m_free) begin
          mvalid_d = 1'b1;
          mdata_d  = {found_q, bw_q, fw_q, cw, pos_q, cnt_q, status_q};
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      free_q   <= '0;
      front_q  <= NullLink;
      back_q   <= NullLink;
      cur_q    <= NullLink;
      cnt_q    <= '0;
      pos_q    <= '1;
      clr_q    <= '0;
      rep_q    <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      free_q   <= free_d;
      front_q  <= front_d;
      back_q   <= back_d;
      cur_q    <= cur_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      clr_q    <= clr_d;
      rep_q    <= rep_d;
      mvalid_q <= mvalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    word_q   <= word_d;
    status_q <= status_d;
    found_q  <= found_d;
    pl_q     <= pl_d;
    ql_q     <= ql_d;
    node_q   <= node_d;
    fw_q     <= fw_d;
    bw_q     <= bw_d;
    mdata_q  <= mdata_d;
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = OUT_TW'(mdata_q);

  // checks
  `include "cursor_list_engine_assert.svh"

  `CLE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_fire, !s_axis_tready_o)
  `CLE_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(POOL_NODES))
  `CLE_ASSERT_NOW(a_cursor_pos, clk_i, rst_ni, 1'b1, (cur_q == NullLink) == (pos_q == '1))
  `CLE_ASSERT_NOW(a_full_count, clk_i, rst_ni, free_q == NullLink, cnt_q == CNT_W'(POOL_NODES))

endmodule

[design/cle_node_mem.sv]
// ---------------------------------------------------------------------------
// cle_node_mem
// node pool storage: data word, next link and prev link memories with one
// shared registered read port and one write port per memory
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cle_node_mem #(
  parameter int unsigned POOL_NODES = cle_pkg::PoolNodesDef,
  parameter int unsigned DATA_WIDTH = cle_pkg::DataWidthDef,
  localparam int unsigned AW = $clog2(POOL_NODES),
  localparam int unsigned LW = $clog2(POOL_NODES + 1)
) (
  input  logic                  clk_i,
  input  logic                  ren_i,
  input  logic [AW-1:0]         raddr_i,
  input  cle_pkg::cle_wen_t     wen_i,
  input  logic [AW-1:0]         d_waddr_i,
  input  logic [DATA_WIDTH-1:0] d_wdata_i,
  input  logic [AW-1:0]         n_waddr_i,
  input  logic [LW-1:0]         n_wdata_i,
  input  logic [AW-1:0]         p_waddr_i,
  input  logic [LW-1:0]         p_wdata_i,
  output logic [DATA_WIDTH-1:0] rd_data_o,
  output logic [LW-1:0]         rd_next_o,
  output logic [LW-1:0]         rd_prev_o
);

  logic [DATA_WIDTH-1:0] data_mem [POOL_NODES];
  logic [LW-1:0]         next_mem [POOL_NODES];
  logic [LW-1:0]         prev_mem [POOL_NODES];

  // write ports
  always_ff @(posedge clk_i) begin
    if (wen_i.data) begin
      data_mem[d_waddr_i] <= d_wdata_i;
    end
    if (wen_i.next) begin
      next_mem[n_waddr_i] <= n_wdata_i;
    end
    if (wen_i.prev) begin
      prev_mem[p_waddr_i] <= p_wdata_i;
    end
  end

  // shared read port, output held while not enabled
  always_ff @(posedge clk_i) begin
    if (ren_i) begin
      rd_data_o <= data_mem[raddr_i];
      rd_next_o <= next_mem[raddr_i];
      rd_prev_o <= prev_mem[raddr_i];
    end
  end

endmodule

[sim/tb_cursor_list_engine.sv]
// ---------------------------------------------------------------------------
// tb_cursor_list_engine
// self-checking bench for the cursor list engine: drives list operations on
// the input stream, predicts each result with a behavioural list and checks
// every result transaction field by field, with random stalls on both sides
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cursor_list_engine;

  localparam int unsigned NODES  = 64;
  localparam int unsigned IN_TW  = 40;
  localparam int unsigned OUT_TW = 120;
  localparam int unsigned NUL    = NODES;
  localparam longint      CYCLE_LIMIT = 1000000;
  // operation code outside the defined set, behaves as a query
  localparam logic [3:0]  FnUnused = 4'd15;

  typedef struct packed {
    logic        found;
    logic [31:0] back_word;
    logic [31:0] front_word;
    logic [31:0] cur_word;
    logic [6:0]  cur_idx;
    logic [6:0]  len;
    logic [1:0]  status;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [IN_TW-1:0] s_data = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OUT_TW-1:0] m_data;

  cursor_list_engine u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #5 clk_i = ~clk_i;

  // shadow list state
  logic [31:0] mem_word [NODES];
  int unsigned link_nx [NODES];
  int unsigned link_pv [NODES];
  int unsigned free_top, head_n, tail_n, cur_n, n_elems;
  int          cur_at;

  list_result_t pending_results[$];
  int  err_count = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  rx_hold = 1'b0;
  longint cycle_cnt = 0;

  task automatic list_reset();
    for (int i = 0; i < NODES; i++) begin
      link_nx[i] = i + 1;
      link_pv[i] = NUL;
    end
    free_top = 0; head_n = NUL; tail_n = NUL; cur_n = NUL;
    n_elems = 0; cur_at = -1;
  endtask

  task automatic link_in(logic [31:0] w, int unsigned p, int unsigned q);
    int unsigned n;
    n = free_top;
    free_top = link_nx[n];
    mem_word[n] = w; link_pv[n] = p; link_nx[n] = q;
    if (p < NUL) link_nx[p] = n; else head_n = n;
    if (q < NUL) link_pv[q] = n; else tail_n = n;
    n_elems++;
  endtask

  task automatic link_out(int unsigned n);
    int unsigned p, q;
    p = link_pv[n]; q = link_nx[n];
    if (p < NUL) link_nx[p] = q; else head_n = q;
    if (q < NUL) link_pv[q] = p; else tail_n = p;
    link_nx[n] = free_top; link_pv[n] = NUL; free_top = n;
    n_elems--;
  endtask

  // apply one operation to the shadow list and return the expected result
  task automatic predict_list_op(logic [3:0] fn, logic [31:0] w, output list_result_t r);
    bit empty, nocur, full;
    int unsigned n;
    cle_pkg::cle_status_e st;
    r = '0;
    st = cle_pkg::ST_OK;
    empty = (n_elems == 0); nocur = (cur_n >= NUL); full = (free_top >= NUL);
    case (fn)
      cle_pkg::FN_CLEAR: list_reset();
      cle_pkg::FN_SET: if (!empty && !nocur) mem_word[cur_n] = w;
      cle_pkg::FN_FRONT: if (!empty) begin cur_n = head_n; cur_at = 0; end
      cle_pkg::FN_BACK: if (!empty) begin cur_n = tail_n; cur_at = n_elems - 1; end
      cle_pkg::FN_PREV: if (!nocur) begin
        if (cur_n == head_n) begin cur_n = NUL; cur_at = -1; end
        else begin cur_n = link_pv[cur_n]; cur_at--; end
      end
      cle_pkg::FN_NEXT: if (!nocur) begin
        if (cur_n == tail_n) begin cur_n = NUL; cur_at = -1; end
        else begin cur_n = link_nx[cur_n]; cur_at++; end
      end
      cle_pkg::FN_PREPEND: if (full) st = cle_pkg::ST_FULL;
        else begin link_in(w, NUL, head_n); if (!nocur) cur_at++; end
      cle_pkg::FN_APPEND: if (full) st = cle_pkg::ST_FULL; else link_in(w, tail_n, NUL);
      cle_pkg::FN_INS_B, cle_pkg::FN_INS_A: begin
        if (empty) st = cle_pkg::ST_EMPTY;
        else if (nocur) st = cle_pkg::ST_NOCUR;
        else if (full) st = cle_pkg::ST_FULL;
        else if (fn == cle_pkg::FN_INS_B) begin
          link_in(w, link_pv[cur_n], cur_n); cur_at++;
        end
        else link_in(w, cur_n, link_nx[cur_n]);
      end
      cle_pkg::FN_DEL_FRONT: if (empty) st = cle_pkg::ST_EMPTY;
        else begin
          n = head_n;
          if (cur_n == n) begin cur_n = NUL; cur_at = -1; end
          else if (!nocur) cur_at--;
          link_out(n);
        end
      cle_pkg::FN_DEL_BACK: if (empty) st = cle_pkg::ST_EMPTY;
        else begin
          n = tail_n;
          if (cur_n == n) begin cur_n = NUL; cur_at = -1; end
          link_out(n);
        end
      cle_pkg::FN_DEL_CUR: if (empty) st = cle_pkg::ST_EMPTY;
        else if (nocur) st = cle_pkg::ST_NOCUR;
        else begin link_out(cur_n); cur_n = NUL; cur_at = -1; end
      cle_pkg::FN_FIND: begin
        n = head_n;
        while (n < NUL) begin
          if (mem_word[n] == w) begin r.found = 1'b1; break; end
          n = link_nx[n];
        end
      end
      default: ;
    endcase
    r.status     = st;
    r.len        = n_elems[6:0];
    r.cur_idx    = cur_at[6:0];
    r.cur_word   = (cur_n < NUL) ? mem_word[cur_n] : '0;
    r.front_word = (head_n < NUL) ? mem_word[head_n] : '0;
    r.back_word  = (tail_n < NUL) ? mem_word[tail_n] : '0;
  endtask

  // offer one operation, with an optional idle burst in front
  task automatic send_op(logic [3:0] fn, logic [31:0] w);
    list_result_t r;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_data  <= {w, fn};
    s_valid <= 1'b1;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    predict_list_op(fn, w, r);
    pending_results.push_back(r);
    @(negedge clk_i);
  endtask

  // receiver stalls
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold) m_ready <= 1'b0;
      else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
        m_ready <= 1'b1;
      end else m_ready <= 1'b1;
    end
  end

  // result checking
  always @(posedge clk_i) begin
    list_result_t got, exp_r;
    if (rst_ni && m_valid && m_ready) begin
      got = list_result_t'(m_data[$bits(list_result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $realtime, got);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.status !== exp_r.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
          err_count++;
        end
        if (got.len !== exp_r.len) begin
          $display("%0t: length exp %0d got %0d", $realtime, exp_r.len, got.len);
          err_count++;
        end
        if (got.cur_idx !== exp_r.cur_idx) begin
          $display("%0t: cursor index exp %0d got %0d", $realtime,
                   $signed(exp_r.cur_idx), $signed(got.cur_idx));
          err_count++;
        end
        if (got.cur_word !== exp_r.cur_word) begin
          $display("%0t: cursor word exp %h got %h", $realtime, exp_r.cur_word, got.cur_word);
          err_count++;
        end
        if (got.front_word !== exp_r.front_word) begin
          $display("%0t: front word exp %h got %h", $realtime,
                   exp_r.front_word, got.front_word);
          err_count++;
        end
        if (got.back_word !== exp_r.back_word) begin
          $display("%0t: back word exp %h got %h", $realtime, exp_r.back_word, got.back_word);
          err_count++;
        end
        if (got.found !== exp_r.found) begin
          $display("%0t: found exp %0b got %0b", $realtime, exp_r.found, got.found);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // a word either new or already in the list, so finds hit and miss
  function automatic logic [31:0] pick_word();
    int unsigned n;
    if ($urandom_range(0, 2) == 0 && head_n < NUL) begin
      n = head_n;
      repeat ($urandom_range(0, n_elems - 1)) n = link_nx[n];
      return mem_word[n];
    end
    return $urandom();
  endfunction

  task automatic test_directed();
    send_op(cle_pkg::FN_QUERY, 32'h0);
    send_op(cle_pkg::FN_DEL_FRONT, 32'h0);
    send_op(cle_pkg::FN_DEL_BACK, 32'h0);
    send_op(cle_pkg::FN_DEL_CUR, 32'h0);
    send_op(cle_pkg::FN_INS_B, 32'h1);
    send_op(cle_pkg::FN_SET, 32'h5);
    send_op(cle_pkg::FN_FRONT, 32'h0);
    send_op(cle_pkg::FN_PREPEND, 32'hFFFF_FFFF);
    send_op(cle_pkg::FN_INS_A, 32'h2);
    send_op(cle_pkg::FN_PREV, 32'h0);
    send_op(cle_pkg::FN_BACK, 32'h0);
    send_op(cle_pkg::FN_PREPEND, 32'h0);
    send_op(cle_pkg::FN_APPEND, 32'hA5A5_5A5A);
    send_op(cle_pkg::FN_INS_B, 32'h5A5A_A5A5);
    send_op(cle_pkg::FN_INS_A, 32'h1234_5678);
    send_op(cle_pkg::FN_SET, 32'h8000_0001);
    send_op(cle_pkg::FN_FIND, 32'h8000_0001);
    send_op(cle_pkg::FN_FIND, 32'hDEAD_BEEF);
    send_op(cle_pkg::FN_NEXT, 32'h0);
    send_op(cle_pkg::FN_NEXT, 32'h0);
    send_op(cle_pkg::FN_FRONT, 32'h0);
    send_op(cle_pkg::FN_DEL_FRONT, 32'h0);
    send_op(cle_pkg::FN_DEL_CUR, 32'h0);
    send_op(FnUnused, 32'h0);
    send_op(cle_pkg::FN_CLEAR, 32'h0);
  endtask

  // fill the pool to the brim, hit the full case, then walk the whole list
  task automatic test_full_pool();
    send_op(cle_pkg::FN_FRONT, 32'h0);
    while (free_top < NUL)
      send_op(4'($urandom_range(cle_pkg::FN_PREPEND, cle_pkg::FN_INS_A)), $urandom());
    send_op(cle_pkg::FN_PREPEND, 32'h1);
    send_op(cle_pkg::FN_APPEND, 32'h2);
    send_op(cle_pkg::FN_INS_B, 32'h3);
    send_op(cle_pkg::FN_INS_A, 32'h4);
    send_op(cle_pkg::FN_FIND, mem_word[tail_n]);
    send_op(cle_pkg::FN_FIND, 32'h0BAD_F00D);
    send_op(cle_pkg::FN_BACK, 32'h0);
    send_op(cle_pkg::FN_NEXT, 32'h0);
    send_op(cle_pkg::FN_CLEAR, 32'h0);
  endtask

  // long receiver hold while operations keep coming
  task automatic test_output_stall();
    rx_hold = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        rx_hold = 1'b0;
      end
      repeat (8) send_op(cle_pkg::FN_APPEND, $urandom());
    join
  endtask

  task automatic test_random(int unsigned count);
    logic [3:0] fn;
    int unsigned k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      // inserts dominate while short, deletes while long
      if (k < 45) fn = 4'($urandom_range(cle_pkg::FN_PREPEND, cle_pkg::FN_INS_A));
      else if (k < 70) fn = 4'($urandom_range(cle_pkg::FN_SET, cle_pkg::FN_NEXT));
      else if (k < 88) fn = 4'($urandom_range(cle_pkg::FN_DEL_FRONT, cle_pkg::FN_DEL_CUR));
      else if (k < 96) fn = cle_pkg::FN_FIND;
      else if (k < 98) fn = cle_pkg::FN_QUERY;
      else if (k < 99) fn = FnUnused;
      else fn = cle_pkg::FN_CLEAR;
      if (n_elems > 56 && fn >= cle_pkg::FN_PREPEND && fn <= cle_pkg::FN_INS_A &&
          $urandom_range(0, 1))
        fn = cle_pkg::FN_DEL_CUR;
      send_op(fn, pick_word());
    end
  endtask

  initial begin
    list_reset();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_pool();
    test_output_stall();
    test_random(900);
    test_full_pool();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random(200);
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/cle_pkg.sv
design/cle_node_mem.sv
design/cursor_list_engine.sv
sim/tb_cursor_list_engine.sv
